/* sv/rmj_pkg.sv */
package rmj_pkg;

	localparam int DataW     = 32;
	localparam int ThrW      = 16;
	localparam int ProdW     = 2 * DataW;      // squares, cross products, rho^2
	localparam int NumLanes  = 4;
	localparam int DivSteps  = ProdW - 1;      // quotient bits below the cap
	localparam int DivRemW   = ProdW - 1;
	localparam int DivNumW   = DataW - 1;      // numerator bits fed in one per step
	localparam int DivHiW    = ProdW - DivNumW;
	localparam int BrgW      = DataW + 1;      // bearing and range quotients
	localparam int SqW       = BrgW + 1;
	localparam int SqrtSteps = BrgW / 2 + 1;
	localparam int RngW      = DataW / 2 + 1;
	localparam int MulW      = RngW + DataW;
	localparam int RateW     = MulW + 1;

	localparam logic [ThrW-1:0]  ThrReset = ThrW'(7);
	localparam logic [BrgW-1:0]  QOne     = {1'b1, {DataW{1'b0}}};
	localparam logic [DataW-1:0] MaxVal   = {1'b0, {(DataW-1){1'b1}}};
	localparam logic [DataW-1:0] MinVal   = {1'b1, {(DataW-1){1'b0}}};

	typedef enum logic [1:0] {
		LANE_SQX = 2'd0,   // px^2
		LANE_APY = 2'd1,   // |py|
		LANE_APX = 2'd2,   // |px|
		LANE_CRS = 2'd3    // |vx py - vy px|
	} lane_t;

	typedef struct packed {
		logic signed [DataW-1:0] pos_x;
		logic signed [DataW-1:0] pos_y;
		logic signed [DataW-1:0] vel_x;
		logic signed [DataW-1:0] vel_y;
	} state_t;

	typedef struct packed {
		logic signed [DataW-1:0] range_by_px;
		logic signed [DataW-1:0] range_by_py;
		logic signed [DataW-1:0] bearing_by_px;
		logic signed [DataW-1:0] bearing_by_py;
		logic signed [DataW-1:0] rate_by_px;
		logic signed [DataW-1:0] rate_by_py;
		logic                    was_clamped;
		logic                    saturated;
	} jac_t;

	typedef struct packed {
		logic px_neg;
		logic py_neg;
		logic cneg;
		logic clamped;
		logic zero;
	} side_t;

	typedef struct packed {
		logic [NumLanes-1:0][ProdW-1:0] num;
		logic [ProdW-1:0]               den;
		side_t                          side;
	} div_in_t;

	typedef struct packed {
		logic [NumLanes-1:0][ProdW-1:0] quo;
		logic                           rem_nz;
		side_t                          side;
	} div_out_t;

	typedef struct packed {
		logic [RngW-1:0]  rng_x;
		logic [RngW-1:0]  rng_y;
		logic [BrgW-1:0]  brg_px;
		logic [BrgW-1:0]  brg_py;
		logic [ProdW-1:0] u;
		side_t            side;
	} sqrt_out_t;

endpackage

/* sv/rmj_front.sv */
module rmj_front import rmj_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            state_valid,
	input  state_t          state,
	output logic            state_stall,
	input  logic [ThrW-1:0] thr,
	output logic            fv,
	output div_in_t         fd
);

	logic [DataW-1:0] ax_in, ay_in, thr_w, thr_neg;
	logic near, load1;
	logic signed [DataW-1:0] px_in, py_in;
	side_t side_in;

	logic v_s1, v_s2, v_s3;
	logic signed [DataW-1:0] px_s1, py_s1, vx_s1, vy_s1;
	side_t side_s1, side_s2, side_s3;
	side_t side_d;

	logic [DataW-1:0] apx, apy;
	logic [ProdW-1:0] sqx, sqy;
	logic signed [ProdW-1:0] pa, pb;
	logic [ProdW-1:0] sqx_s2, sqy_s2, sqx_s3;
	logic signed [ProdW-1:0] pa_s2, pb_s2;
	logic [DataW-1:0] apx_s2, apy_s2, apx_s3, apy_s3;

	logic [ProdW-1:0] rho2_s3;
	logic [ProdW:0]   diff_s3, diff_neg;

	// stage 1: near-zero guard
	assign thr_w   = DataW'(thr);
	assign thr_neg = -thr_w;
	assign ax_in   = state.pos_x[DataW-1] ? DataW'(-state.pos_x) : state.pos_x;
	assign ay_in   = state.pos_y[DataW-1] ? DataW'(-state.pos_y) : state.pos_y;
	assign near    = (ax_in < thr_w) && (ay_in < thr_w);
	assign px_in   = near ? ((!state.pos_x[DataW-1] && state.pos_x != '0) ? thr_w : thr_neg)
	                      : state.pos_x;
	assign py_in   = near ? ((!state.pos_y[DataW-1] && state.pos_y != '0) ? thr_w : thr_neg)
	                      : state.pos_y;

	always_comb begin
		side_in         = '0;
		side_in.px_neg  = px_in[DataW-1];
		side_in.py_neg  = py_in[DataW-1];
		side_in.clamped = near;
	end

	// stage 1 refills when empty even while the rest is held
	assign load1       = adv | ~v_s1;
	assign state_stall = v_s1 & ~adv;

	// stage 2: squares and cross products
	assign apx = px_s1[DataW-1] ? DataW'(-px_s1) : px_s1;
	assign apy = py_s1[DataW-1] ? DataW'(-py_s1) : py_s1;
	assign sqx = apx * apx;
	assign sqy = apy * apy;
	assign pa  = vx_s1 * py_s1;
	assign pb  = vy_s1 * px_s1;

	assign diff_neg = -diff_s3;

	always_comb begin
		side_d      = side_s3;
		side_d.cneg = diff_s3[ProdW];
		side_d.zero = (rho2_s3 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			fv   <= 1'b0;
		end else begin
			if (load1) v_s1 <= state_valid;
			if (adv) begin
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				fv   <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			px_s1   <= px_in;
			py_s1   <= py_in;
			vx_s1   <= state.vel_x;
			vy_s1   <= state.vel_y;
			side_s1 <= side_in;
		end
		if (adv) begin
			sqx_s2  <= sqx;
			sqy_s2  <= sqy;
			pa_s2   <= pa;
			pb_s2   <= pb;
			apx_s2  <= apx;
			apy_s2  <= apy;
			side_s2 <= side_s1;

			// stage 3: rho^2 and signed cross term
			rho2_s3 <= sqx_s2 + sqy_s2;
			diff_s3 <= {pa_s2[ProdW-1], pa_s2} - {pb_s2[ProdW-1], pb_s2};
			sqx_s3  <= sqx_s2;
			apx_s3  <= apx_s2;
			apy_s3  <= apy_s2;
			side_s3 <= side_s2;

			// stage 4: divider operands
			fd.num[LANE_SQX] <= sqx_s3;
			fd.num[LANE_APY] <= ProdW'(apy_s3);
			fd.num[LANE_APX] <= ProdW'(apx_s3);
			fd.num[LANE_CRS] <= diff_s3[ProdW] ? diff_neg[ProdW-1:0] : diff_s3[ProdW-1:0];
			fd.den           <= rho2_s3;
			fd.side          <= side_d;
		end
	end

endmodule

/* sv/rmj_div.sv */
module rmj_div import rmj_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     iv,
	input  div_in_t  id,
	output logic     ov,
	output div_out_t od
);

	// four restoring dividers sharing rho^2: q = min(floor(num * 2^32 / den), 2^63)
	typedef struct packed {
		logic [NumLanes-1:0][DivRemW-1:0]  rem;
		logic [NumLanes-1:0][DivSteps-1:0] quo;
		logic [NumLanes-1:0][DivNumW-1:0]  nsh;
		logic [NumLanes-1:0]               cap;
		logic [ProdW-1:0]                  den;
		side_t                             side;
	} div_st_t;

	div_st_t st_s [DivSteps+1];
	logic [DivSteps:0] v_s;

	function automatic div_st_t div_init(div_in_t d);
		div_st_t s;
		logic [DivHiW-1:0] hi;
		s      = '0;
		s.den  = d.den;
		s.side = d.side;
		for (int l = 0; l < NumLanes; l++) begin
			hi       = d.num[l][ProdW-1:DivNumW];
			// top part already >= den: quotient reaches the cap
			s.cap[l] = ProdW'(hi) >= d.den;
			s.rem[l] = s.cap[l] ? '0 : DivRemW'(hi);
			s.nsh[l] = d.num[l][DivNumW-1:0];
		end
		return s;
	endfunction

	function automatic div_st_t div_step(div_st_t s);
		div_st_t n;
		logic [ProdW-1:0] t;
		n = s;
		for (int l = 0; l < NumLanes; l++) begin
			t        = {s.rem[l], s.nsh[l][DivNumW-1]};
			n.nsh[l] = {s.nsh[l][DivNumW-2:0], 1'b0};
			if (t >= s.den) begin
				n.rem[l] = DivRemW'(t - s.den);
				n.quo[l] = {s.quo[l][DivSteps-2:0], 1'b1};
			end else begin
				n.rem[l] = t[DivRemW-1:0];
				n.quo[l] = {s.quo[l][DivSteps-2:0], 1'b0};
			end
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DivSteps-1:0], iv};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= div_init(id);
			for (int k = 0; k < DivSteps; k++) begin
				st_s[k+1] <= div_step(st_s[k]);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NumLanes; l++) begin
			od.quo[l] = st_s[DivSteps].cap[l] ? (ProdW'(1) << DivSteps)
			                                  : ProdW'(st_s[DivSteps].quo[l]);
		end
		od.rem_nz = |st_s[DivSteps].rem[LANE_SQX];
		od.side   = st_s[DivSteps].side;
	end

	assign ov = v_s[DivSteps];

endmodule

/* sv/rmj_sqrt.sv */
module rmj_sqrt import rmj_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      iv,
	input  div_out_t  id,
	output logic      ov,
	output sqrt_out_t od
);

	// lane 0: x, lane 1: y; one result bit pair per stage
	typedef struct packed {
		logic [1:0][SqW-1:0] val;
		logic [1:0][SqW-1:0] res;
		logic [BrgW-1:0]     brg_px;
		logic [BrgW-1:0]     brg_py;
		logic [ProdW-1:0]    u;
		side_t               side;
	} sq_st_t;

	sq_st_t st_s [SqrtSteps+1];
	logic [SqrtSteps:0] v_s;
	sq_st_t prep;
	logic [BrgW-1:0] qx, qy;

	function automatic sq_st_t sq_step(sq_st_t s, logic [SqW-1:0] bitv);
		sq_st_t n;
		logic [SqW-1:0] sum;
		n = s;
		for (int l = 0; l < 2; l++) begin
			sum = s.res[l] + bitv;
			if (s.val[l] >= sum) begin
				n.val[l] = s.val[l] - sum;
				n.res[l] = (s.res[l] >> 1) + bitv;
			end else begin
				n.res[l] = s.res[l] >> 1;
			end
		end
		return n;
	endfunction

	// y^2/rho^2 quotient follows from the x one: they sum to 2^32, less one if inexact
	assign qx = id.quo[LANE_SQX][BrgW-1:0];
	assign qy = QOne - qx - BrgW'(id.rem_nz);

	always_comb begin
		prep        = '0;
		prep.val[0] = SqW'(qx);
		prep.val[1] = SqW'(qy);
		prep.brg_px = id.quo[LANE_APY][BrgW-1:0];
		prep.brg_py = id.quo[LANE_APX][BrgW-1:0];
		prep.u      = id.quo[LANE_CRS];
		prep.side   = id.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[SqrtSteps-1:0], iv};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= prep;
			for (int k = 0; k < SqrtSteps; k++) begin
				st_s[k+1] <= sq_step(st_s[k], SqW'(1) << (2 * (SqrtSteps - 1 - k)));
			end
		end
	end

	always_comb begin
		od.rng_x  = st_s[SqrtSteps].res[0][RngW-1:0];
		od.rng_y  = st_s[SqrtSteps].res[1][RngW-1:0];
		od.brg_px = st_s[SqrtSteps].brg_px;
		od.brg_py = st_s[SqrtSteps].brg_py;
		od.u      = st_s[SqrtSteps].u;
		od.side   = st_s[SqrtSteps].side;
	end

	assign ov = v_s[SqrtSteps];

endmodule

/* sv/rmj_tail.sv */
module rmj_tail import rmj_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      iv,
	input  sqrt_out_t id,
	output logic      ov,
	output jac_t      od
);

	logic v_s1, v_s2;
	sqrt_out_t mid_s1, mid_s2;
	logic [MulW-1:0] ph_x, pl_x, ph_y, pl_y;
	logic [MulW-1:0] ph_x_s1, pl_x_s1, ph_y_s1, pl_y_s1;
	logic [RateW-1:0] rate_x_s2, rate_y_s2;
	logic [DataW:0] r0, r1, r2, r3, r4, r5;
	jac_t res;

	// {saturated, value}
	function automatic logic [DataW:0] sat_val(logic neg, logic [RateW-1:0] mag);
		logic [DataW:0] r;
		if (mag == '0) begin
			r = '0;
		end else if (neg) begin
			if (mag > RateW'(MinVal)) r = {1'b1, MinVal};
			else                      r = {1'b0, DataW'(-mag)};
		end else begin
			if (mag > RateW'(MaxVal)) r = {1'b1, MaxVal};
			else                      r = {1'b0, mag[DataW-1:0]};
		end
		return r;
	endfunction

	// range * u / 2^32, u split in halves
	assign ph_x = id.rng_x * id.u[ProdW-1:DataW];
	assign pl_x = id.rng_x * id.u[DataW-1:0];
	assign ph_y = id.rng_y * id.u[ProdW-1:DataW];
	assign pl_y = id.rng_y * id.u[DataW-1:0];

	assign r0 = sat_val(mid_s2.side.px_neg, RateW'(mid_s2.rng_x));
	assign r1 = sat_val(mid_s2.side.py_neg, RateW'(mid_s2.rng_y));
	assign r2 = sat_val(!mid_s2.side.py_neg, RateW'(mid_s2.brg_px));
	assign r3 = sat_val(mid_s2.side.px_neg, RateW'(mid_s2.brg_py));
	assign r4 = sat_val(mid_s2.side.py_neg ^ mid_s2.side.cneg, rate_y_s2);
	assign r5 = sat_val(mid_s2.side.px_neg ^ !mid_s2.side.cneg, rate_x_s2);

	always_comb begin
		if (mid_s2.side.zero) begin
			res           = '0;
			res.saturated = 1'b1;
		end else begin
			res.range_by_px   = r0[DataW-1:0];
			res.range_by_py   = r1[DataW-1:0];
			res.bearing_by_px = r2[DataW-1:0];
			res.bearing_by_py = r3[DataW-1:0];
			res.rate_by_px    = r4[DataW-1:0];
			res.rate_by_py    = r5[DataW-1:0];
			res.was_clamped   = mid_s2.side.clamped;
			res.saturated     = r0[DataW] | r1[DataW] | r2[DataW] | r3[DataW]
			                  | r4[DataW] | r5[DataW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov   <= 1'b0;
		end else if (en) begin
			v_s1 <= iv;
			v_s2 <= v_s1;
			ov   <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1    <= id;
			ph_x_s1   <= ph_x;
			pl_x_s1   <= pl_x;
			ph_y_s1   <= ph_y;
			pl_y_s1   <= pl_y;
			mid_s2    <= mid_s1;
			rate_x_s2 <= RateW'(ph_x_s1) + RateW'(pl_x_s1[MulW-1:DataW]);
			rate_y_s2 <= RateW'(ph_y_s1) + RateW'(pl_y_s1[MulW-1:DataW]);
			od        <= res;
		end
	end

endmodule

/* sv/radar_measurement_jacobian.sv */
// Radar measurement Jacobian for one tracked state (px, py, vx, vy, signed Q15.16).
// Channels:
//   state  : input beat, taken when state_valid is high and state_stall low.
//   jac    : result beat (six partials plus clamp and saturation flags), taken
//            when jac_valid is high and jac_stall low.
//   cfg    : near-zero threshold write, taken when cfg_valid and cfg_ready are
//            high; cfg_ready is always high. Write only while the block is idle.
// From an accepted state beat to its jac beat the pipeline runs through 4 front
// stages (guard, multiplies, rho^2 and cross term, operand set-up), 64 divider
// stages (set-up, then one quotient bit per stage, four dividers in parallel),
// 18 square root stages and 3 tail stages (range times rate quotient, sum,
// saturation). Throughput is one beat per cycle while jac is not stalled; the
// 64-stage divider sets the depth. The last tail stage is the output register.
// While jac is stalled with a beat waiting, the pipeline holds and loses nothing;
// the first stage still takes one more state beat if it is empty. Reset clears
// all valid bits and sets the threshold to 7.
module radar_measurement_jacobian import rmj_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [ThrW-1:0] cfg_data,
	input  logic            state_valid,
	output logic            state_stall,
	input  state_t          state,
	output logic            jac_valid,
	input  logic            jac_stall,
	output jac_t            jac
);

	logic [ThrW-1:0] thr_q;
	logic adv;

	logic      fv, dv, sv;
	div_in_t   fd;
	div_out_t  dd;
	sqrt_out_t sd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ThrReset;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// whole pipeline moves when the output register is empty or being taken
	assign adv = ~jac_valid | ~jac_stall;

	rmj_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.state_valid (state_valid),
		.state       (state),
		.state_stall (state_stall),
		.thr         (thr_q),
		.fv          (fv),
		.fd          (fd)
	);

	rmj_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.iv     (fv),
		.id     (fd),
		.ov     (dv),
		.od     (dd)
	);

	rmj_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.iv     (dv),
		.id     (dd),
		.ov     (sv),
		.od     (sd)
	);

	rmj_tail u_tail (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.iv     (sv),
		.id     (sd),
		.ov     (jac_valid),
		.od     (jac)
	);

endmodule
